// ----- hw/rtl/pss_pkg.sv -----
// Shared types, constants and arithmetic helpers of the paddle shift sequencer.
package pss_pkg;

	localparam int CNT_W = 16;
	localparam int CMP_W = (CNT_W > 16) ? CNT_W : 16;
	localparam int ADDR_W = 5;
	localparam int DATA_W = 32;
	localparam int PROD_W = 24;

	localparam logic [2:0] ST_IDLE      = 3'd0;
	localparam logic [2:0] ST_UP        = 3'd1;
	localparam logic [2:0] ST_DOWN      = 3'd2;
	localparam logic [2:0] ST_UP_COOL   = 3'd3;
	localparam logic [2:0] ST_DOWN_COOL = 3'd4;
	localparam logic [2:0] ST_NREQ      = 3'd5;
	localparam logic [2:0] ST_NEUTRAL   = 3'd6;

	localparam logic [2:0] REG_SHIFT_HOLD   = 3'd0;
	localparam logic [2:0] REG_COOLDOWN     = 3'd1;
	localparam logic [2:0] REG_NEUTRAL_HOLD = 3'd2;
	localparam logic [2:0] REG_UP_POS       = 3'd3;
	localparam logic [2:0] REG_DOWN_POS     = 3'd4;
	localparam logic [2:0] REG_NEUTRAL_POS  = 3'd5;
	localparam logic [2:0] REG_HOME_POS     = 3'd6;
	localparam logic [2:0] REG_PWM_PERIOD   = 3'd7;

	localparam logic [15:0] RST_SHIFT_HOLD   = 16'd400;
	localparam logic [15:0] RST_COOLDOWN     = 16'd300;
	localparam logic [15:0] RST_NEUTRAL_HOLD = 16'd1000;
	localparam logic [6:0]  RST_UP_POS       = 7'd84;
	localparam logic [6:0]  RST_DOWN_POS     = 7'd16;
	localparam logic [6:0]  RST_NEUTRAL_POS  = 7'd69;
	localparam logic [6:0]  RST_HOME_POS     = 7'd50;
	localparam logic [15:0] RST_PWM_PERIOD   = 16'd41995;

	localparam logic [11:0] PEDAL_THRESH = 12'd2800;
	localparam logic [11:0] PEDAL_OFFSET = 12'd3100;
	localparam logic [7:0]  CLUTCH_MIN   = 8'd30;
	localparam logic [7:0]  CLUTCH_MAX   = 8'd100;
	localparam logic [6:0]  CLUTCH_BASE  = 7'd10;
	localparam logic [6:0]  DUTY_MIN     = 7'd3;
	localparam logic [6:0]  DUTY_MAX     = 7'd97;

	// ceil(2^30 / 100): exact quotient for any dividend below 2^23
	localparam logic [PROD_W-1:0] RECIP_100 = 24'd10737419;
	localparam int RECIP_SHIFT = 30;

	typedef struct packed {
		logic [15:0] shift_hold;
		logic [15:0] cooldown;
		logic [15:0] neutral_hold;
		logic [6:0]  up_pos;
		logic [6:0]  down_pos;
		logic [6:0]  neutral_pos;
		logic [6:0]  home_pos;
		logic [15:0] pwm_period;
	} cfg_t;

	typedef struct packed {
		logic        up_button;
		logic        down_button;
		logic        neutral_button;
		logic [11:0] pedal_sample;
	} tick_t;

	typedef struct packed {
		logic [6:0]        shift_position;
		logic [6:0]        clutch_position;
		logic              gear_cut;
		logic [2:0]        mode;
		logic [PROD_W-1:0] shift_prod;
		logic [PROD_W-1:0] clutch_prod;
	} stage_t;

	// x / 5 for x below 1024
	function automatic logic [7:0] div5(input logic [9:0] x);
		logic [17:0] p;
		p = 18'(x) * 18'd205;
		return p[17:10];
	endfunction

	function automatic logic [6:0] clamp_duty(input logic [6:0] d);
		logic [6:0] r;
		r = d;
		if (r > DUTY_MAX) r = DUTY_MAX;
		if (r < DUTY_MIN) r = DUTY_MIN;
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (c == {CNT_W{1'b1}}) ? c : c + CNT_W'(1);
	endfunction

endpackage

// ----- hw/rtl/pss_ifs.sv -----
// Valid/ready channel interfaces for tick requests and results.
interface pss_in_if;
	logic        valid;
	logic        ready;
	logic        up_button;
	logic        down_button;
	logic        neutral_button;
	logic [11:0] pedal_sample;

	modport source (output valid, output up_button, output down_button,
		output neutral_button, output pedal_sample, input ready);
	modport sink (input valid, input up_button, input down_button,
		input neutral_button, input pedal_sample, output ready);
endinterface

interface pss_out_if;
	logic        valid;
	logic        ready;
	logic [6:0]  shift_position;
	logic [6:0]  clutch_position;
	logic [15:0] shift_compare;
	logic [15:0] clutch_compare;
	logic        gear_cut;
	logic [2:0]  mode;

	modport source (output valid, output shift_position, output clutch_position,
		output shift_compare, output clutch_compare, output gear_cut, output mode,
		input ready);
	modport sink (input valid, input shift_position, input clutch_position,
		input shift_compare, input clutch_compare, input gear_cut, input mode,
		output ready);
endinterface

// ----- hw/rtl/pss_apb_regs.sv -----
// APB configuration register file of the paddle shift sequencer.
module pss_apb_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pss_pkg::ADDR_W-1:0] paddr,
	input  logic [pss_pkg::DATA_W-1:0] pwdata,
	output logic [pss_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	output pss_pkg::cfg_t               cfg
);

	pss_pkg::cfg_t cfg_q;
	logic [2:0]    idx;
	logic          wr;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr     = psel && penable && pwrite && pready;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shift_hold   <= pss_pkg::RST_SHIFT_HOLD;
			cfg_q.cooldown     <= pss_pkg::RST_COOLDOWN;
			cfg_q.neutral_hold <= pss_pkg::RST_NEUTRAL_HOLD;
			cfg_q.up_pos       <= pss_pkg::RST_UP_POS;
			cfg_q.down_pos     <= pss_pkg::RST_DOWN_POS;
			cfg_q.neutral_pos  <= pss_pkg::RST_NEUTRAL_POS;
			cfg_q.home_pos     <= pss_pkg::RST_HOME_POS;
			cfg_q.pwm_period   <= pss_pkg::RST_PWM_PERIOD;
		end else if (wr) begin
			unique case (idx)
				pss_pkg::REG_SHIFT_HOLD:   cfg_q.shift_hold   <= pwdata[15:0];
				pss_pkg::REG_COOLDOWN:     cfg_q.cooldown     <= pwdata[15:0];
				pss_pkg::REG_NEUTRAL_HOLD: cfg_q.neutral_hold <= pwdata[15:0];
				pss_pkg::REG_UP_POS:       cfg_q.up_pos       <= pwdata[6:0];
				pss_pkg::REG_DOWN_POS:     cfg_q.down_pos     <= pwdata[6:0];
				pss_pkg::REG_NEUTRAL_POS:  cfg_q.neutral_pos  <= pwdata[6:0];
				pss_pkg::REG_HOME_POS:     cfg_q.home_pos     <= pwdata[6:0];
				pss_pkg::REG_PWM_PERIOD:   cfg_q.pwm_period   <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			pss_pkg::REG_SHIFT_HOLD:   prdata = 32'(cfg_q.shift_hold);
			pss_pkg::REG_COOLDOWN:     prdata = 32'(cfg_q.cooldown);
			pss_pkg::REG_NEUTRAL_HOLD: prdata = 32'(cfg_q.neutral_hold);
			pss_pkg::REG_UP_POS:       prdata = 32'(cfg_q.up_pos);
			pss_pkg::REG_DOWN_POS:     prdata = 32'(cfg_q.down_pos);
			pss_pkg::REG_NEUTRAL_POS:  prdata = 32'(cfg_q.neutral_pos);
			pss_pkg::REG_HOME_POS:     prdata = 32'(cfg_q.home_pos);
			pss_pkg::REG_PWM_PERIOD:   prdata = 32'(cfg_q.pwm_period);
			default:                   prdata = '0;
		endcase
	end

endmodule

// ----- hw/rtl/pss_seq.sv -----
// Input register, clutch request, shift sequencer and duty products.
module pss_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  pss_pkg::cfg_t   cfg,
	pss_in_if.sink          tick,
	output pss_pkg::stage_t payload_s2,
	output logic            valid_s2,
	input  logic            ready_s2
);

	pss_pkg::tick_t  in_s1;
	logic            valid_s1;
	logic            adv1;
	pss_pkg::stage_t nxt;

	logic [2:0]                st_q, st_n;
	logic [pss_pkg::CNT_W-1:0] cnt_q, cnt_n;
	logic [6:0]                sp_q, sp_n;
	logic [6:0]                req_q, req_n;
	logic                      gc_q, gc_n;

	logic       up, dn, neu;
	logic [7:0] req_w;
	logic [7:0] clutch_frac;
	logic [6:0] clutch;
	logic [pss_pkg::PROD_W-1:0] period;

	assign adv1       = !valid_s2 || ready_s2;
	assign tick.ready = !valid_s1 || adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick.ready && tick.valid) begin
			in_s1.up_button      <= tick.up_button;
			in_s1.down_button    <= tick.down_button;
			in_s1.neutral_button <= tick.neutral_button;
			in_s1.pedal_sample   <= tick.pedal_sample;
		end
	end

	always_comb begin
		up    = !in_s1.up_button;
		dn    = !in_s1.down_button;
		neu   = in_s1.neutral_button;
		req_w = {1'b0, req_q};
		if (in_s1.pedal_sample > pss_pkg::PEDAL_THRESH) begin
			if (in_s1.pedal_sample >= pss_pkg::PEDAL_OFFSET)
				req_w = pss_pkg::div5(10'(in_s1.pedal_sample - pss_pkg::PEDAL_OFFSET));
			else
				req_w = '0;
		end
		if (req_w < pss_pkg::CLUTCH_MIN) req_w = pss_pkg::CLUTCH_MIN;
		if (req_w > pss_pkg::CLUTCH_MAX) req_w = pss_pkg::CLUTCH_MAX;
		if (up && dn) begin
			up    = 1'b0;
			dn    = 1'b0;
			req_w = pss_pkg::CLUTCH_MAX;
		end
		req_n       = req_w[6:0];
		clutch_frac = pss_pkg::div5({2'b00, req_n, 1'b0});
		clutch      = pss_pkg::CLUTCH_BASE + clutch_frac[6:0];

		st_n = st_q;
		cnt_n = cnt_q;
		sp_n = sp_q;
		gc_n = gc_q;
		unique case (st_q)
			pss_pkg::ST_UP: begin
				cnt_n = pss_pkg::sat_inc(cnt_q);
				sp_n  = cfg.up_pos;
				gc_n  = 1'b0;
				if (cnt_n < pss_pkg::CNT_W'(3) && dn) begin
					sp_n  = cfg.home_pos;
					gc_n  = 1'b1;
					cnt_n = '0;
					st_n  = pss_pkg::ST_IDLE;
				end
				if (pss_pkg::CMP_W'(cnt_n) > pss_pkg::CMP_W'(cfg.shift_hold)) begin
					st_n  = pss_pkg::ST_UP_COOL;
					gc_n  = 1'b1;
					cnt_n = '0;
				end
			end
			pss_pkg::ST_DOWN: begin
				cnt_n = pss_pkg::sat_inc(cnt_q);
				sp_n  = cfg.down_pos;
				if (cnt_n < pss_pkg::CNT_W'(2) && up) begin
					sp_n  = cfg.home_pos;
					cnt_n = '0;
					st_n  = pss_pkg::ST_IDLE;
				end
				if (pss_pkg::CMP_W'(cnt_n) > pss_pkg::CMP_W'(cfg.shift_hold)) begin
					st_n  = pss_pkg::ST_DOWN_COOL;
					cnt_n = '0;
				end
			end
			pss_pkg::ST_UP_COOL, pss_pkg::ST_DOWN_COOL: begin
				cnt_n = pss_pkg::sat_inc(cnt_q);
				sp_n  = cfg.home_pos;
				if (pss_pkg::CMP_W'(cnt_n) > pss_pkg::CMP_W'(cfg.cooldown)) begin
					st_n  = pss_pkg::ST_IDLE;
					cnt_n = '0;
				end
			end
			pss_pkg::ST_NREQ: begin
				cnt_n = pss_pkg::sat_inc(cnt_q);
				if (!neu) begin
					st_n  = pss_pkg::ST_IDLE;
					cnt_n = '0;
				end
				if (pss_pkg::CMP_W'(cnt_n) > pss_pkg::CMP_W'(cfg.neutral_hold)) begin
					st_n  = pss_pkg::ST_NEUTRAL;
					cnt_n = '0;
				end
			end
			pss_pkg::ST_NEUTRAL: begin
				cnt_n = pss_pkg::sat_inc(cnt_q);
				sp_n  = (pss_pkg::CMP_W'(cnt_n) < pss_pkg::CMP_W'(cfg.shift_hold)) ?
					cfg.neutral_pos : cfg.home_pos;
				if (up) begin
					st_n  = pss_pkg::ST_UP;
					cnt_n = pss_pkg::CNT_W'(3);
				end
				if (dn) begin
					st_n  = pss_pkg::ST_DOWN;
					cnt_n = pss_pkg::CNT_W'(3);
				end
				if (neu) st_n = pss_pkg::ST_NREQ;
			end
			default: begin
				st_n = pss_pkg::ST_IDLE;
				if (up)  st_n = pss_pkg::ST_UP;
				if (dn)  st_n = pss_pkg::ST_DOWN;
				if (neu) st_n = pss_pkg::ST_NREQ;
			end
		endcase

		period              = pss_pkg::PROD_W'(cfg.pwm_period) + pss_pkg::PROD_W'(1);
		nxt.shift_position  = sp_n;
		nxt.clutch_position = clutch;
		nxt.gear_cut        = gc_n;
		nxt.mode            = st_n;
		nxt.shift_prod      = period * pss_pkg::PROD_W'(pss_pkg::clamp_duty(sp_n));
		nxt.clutch_prod     = period * pss_pkg::PROD_W'(pss_pkg::clamp_duty(clutch));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= pss_pkg::ST_IDLE;
			cnt_q    <= '0;
			sp_q     <= pss_pkg::RST_HOME_POS;
			req_q    <= '0;
			gc_q     <= 1'b1;
			valid_s2 <= 1'b0;
		end else if (adv1) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				st_q  <= st_n;
				cnt_q <= cnt_n;
				sp_q  <= sp_n;
				req_q <= req_n;
				gc_q  <= gc_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && valid_s1) payload_s2 <= nxt;
	end

	a_cut_only_up: assert property (@(posedge clk) disable iff (!arst_n)
		!gc_q |-> st_q == pss_pkg::ST_UP)
		else $error("gear cut active outside upshift");

	a_idle_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == pss_pkg::ST_IDLE |-> cnt_q == '0)
		else $error("tick counter not cleared in idle");

	a_s2_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !ready_s2 |=> valid_s2 && $stable(payload_s2))
		else $error("stage two changed while stalled");

	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && adv1) |=> $stable(st_q) && $stable(cnt_q))
		else $error("sequencer advanced without a request");

endmodule

// ----- hw/rtl/pss_pwm.sv -----
// Scales duty products to PWM compare values and holds the result register.
module pss_pwm (
	input  logic            clk,
	input  logic            arst_n,
	input  pss_pkg::stage_t payload_s2,
	input  logic            valid_s2,
	output logic            ready_s2,
	pss_out_if.source       result
);

	logic        valid_q;
	logic [47:0] shift_m, clutch_m;
	logic [15:0] shift_div, clutch_div;
	logic [6:0]  shift_pos_q, clutch_pos_q;
	logic [15:0] shift_cmp_q, clutch_cmp_q;
	logic        gear_cut_q;
	logic [2:0]  mode_q;

	assign ready_s2 = !valid_q || result.ready;

	assign shift_m    = 48'(payload_s2.shift_prod) * 48'(pss_pkg::RECIP_100);
	assign clutch_m   = 48'(payload_s2.clutch_prod) * 48'(pss_pkg::RECIP_100);
	assign shift_div  = shift_m[pss_pkg::RECIP_SHIFT +: 16];
	assign clutch_div = clutch_m[pss_pkg::RECIP_SHIFT +: 16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ready_s2) begin
			valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s2) begin
			shift_pos_q  <= payload_s2.shift_position;
			clutch_pos_q <= payload_s2.clutch_position;
			gear_cut_q   <= payload_s2.gear_cut;
			mode_q       <= payload_s2.mode;
			shift_cmp_q  <= (shift_div == '0) ? '0 : shift_div - 16'd1;
			clutch_cmp_q <= (clutch_div == '0) ? '0 : clutch_div - 16'd1;
		end
	end

	assign result.valid           = valid_q;
	assign result.shift_position  = shift_pos_q;
	assign result.clutch_position = clutch_pos_q;
	assign result.shift_compare   = shift_cmp_q;
	assign result.clutch_compare  = clutch_cmp_q;
	assign result.gear_cut        = gear_cut_q;
	assign result.mode            = mode_q;

	a_load: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ready_s2 |=> valid_q)
		else $error("stage two request lost");

endmodule

// ----- hw/rtl/paddle_shift_sequencer_unit.sv -----
// Top level of the paddle shift sequencer: config port, sequencer and PWM scaling.
// Pipeline: a request passes the input, sequencer and result registers, in that order.
// Throughput: one request per cycle until result back-pressure fills the pipeline.
// Backpressure: each stage holds while its successor is full, so bubbles are absorbed.
// Reset: asynchronous, active low; sequencer idle, counter zero, servo at 50, gear cut high.
// Reset: configuration registers return to their documented defaults.
module paddle_shift_sequencer_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [pss_pkg::ADDR_W-1:0] paddr,
	input  logic [pss_pkg::DATA_W-1:0] pwdata,
	output logic [pss_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	pss_in_if.sink                      tick,
	pss_out_if.source                   result
);

	pss_pkg::cfg_t   cfg;
	pss_pkg::stage_t payload_s2;
	logic            valid_s2;
	logic            ready_s2;

	pss_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pss_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.tick       (tick),
		.payload_s2 (payload_s2),
		.valid_s2   (valid_s2),
		.ready_s2   (ready_s2)
	);

	pss_pwm u_pwm (
		.clk        (clk),
		.arst_n     (arst_n),
		.payload_s2 (payload_s2),
		.valid_s2   (valid_s2),
		.ready_s2   (ready_s2),
		.result     (result)
	);

endmodule
